FILE: rtl/core/dirty_rect_frame_scheduler_core_assert.svh
// ----------------------------------------------------------------------------
// Dirty rectangle scheduler assertion macros
// Implication checks on the core clock, off in synthesis.
// ----------------------------------------------------------------------------
`ifndef DIRTY_RECT_FRAME_SCHEDULER_CORE_ASSERT_SVH
`define DIRTY_RECT_FRAME_SCHEDULER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DRFS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("drfs: same-cycle check failed");
`define DRFS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("drfs: next-cycle check failed");
`else
`define DRFS_ASSERT_SAME(lbl, ante, cons)
`define DRFS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/drfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drfs_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package drfs_pkg;

    localparam int DIRTY_DEPTH_DEF  = 16;
    localparam int REGION_DEPTH_DEF = 8;
    localparam int COORD_BITS_DEF   = 16;

    localparam int OP_BITS   = 3;
    localparam int ID_BITS   = 16;
    localparam int FPS_BITS  = 12;
    localparam int TIME_BITS = 48;
    localparam int KIND_BITS = 2;
    localparam int STAT_BITS = 2;
    localparam int CFG_IDX_BITS = 2;

    localparam int FRAME_MS  = 1000;
    localparam int MS_BITS   = 10;
    localparam int MSP_BITS  = MS_BITS + 1;
    localparam int DUE_BITS  = MSP_BITS + FPS_BITS;

    localparam int BOUND_LEFT_RST   = 0;
    localparam int BOUND_TOP_RST    = 0;
    localparam int BOUND_RIGHT_RST  = 1920;
    localparam int BOUND_BOTTOM_RST = 1080;

    localparam logic [OP_BITS-1:0] OP_INVALIDATE = 3'd0;
    localparam logic [OP_BITS-1:0] OP_SET        = 3'd1;
    localparam logic [OP_BITS-1:0] OP_CLEAR      = 3'd2;
    localparam logic [OP_BITS-1:0] OP_QUERY      = 3'd3;
    localparam logic [OP_BITS-1:0] OP_CONSUME    = 3'd4;
    localparam logic [OP_BITS-1:0] OP_RESET      = 3'd5;

    localparam logic [KIND_BITS-1:0] KIND_ACK  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_RECT = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_PEND = 2'd2;

    localparam logic [STAT_BITS-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_IGNORED    = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_FULL_MERGE = 2'd2;
    localparam logic [STAT_BITS-1:0] ST_TABLE_FULL = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_BOUND_LEFT   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOUND_TOP    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOUND_RIGHT  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOUND_BOTTOM = 2'd3;

    typedef enum logic [4:0] {
        UOP_IDLE,
        UOP_DECODE,
        UOP_MINIT,
        UOP_MREAD,
        UOP_MAE,
        UOP_MAU,
        UOP_MCMP,
        UOP_RREAD,
        UOP_RCHK,
        UOP_RDUE,
        UOP_RNEXT,
        UOP_SNEW,
        UOP_EREAD,
        UOP_ECLIP,
        UOP_EEND,
        UOP_ACK,
        UOP_PANS
    } uop_t;

    typedef struct packed {
        logic [OP_BITS-1:0] op;
        logic               bad;
        logic               dirty_any;
        logic               i_end;
        logic               k_end;
        logic               fit;
        logic               hit;
        logic               due;
        logic               clip_ok;
        logic               hold_v;
        logic               obuf_free;
    } sts_t;

endpackage

FILE: rtl/core/drfs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drfs_ctrl
// Sequencer: walks each word through decode, list merge, region scan and
// rectangle emission, issuing one micro-op per cycle to the datapath.
// ----------------------------------------------------------------------------
module drfs_ctrl import drfs_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  sts_t sts,
    output uop_t uop
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_MINIT,
        S_MREAD,
        S_MAE,
        S_MAU,
        S_MCMP,
        S_RREAD,
        S_RCHK,
        S_RDUE,
        S_RNEXT,
        S_SNEW,
        S_EREAD,
        S_ECLIP,
        S_EEND,
        S_ACK,
        S_PANS
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t merge_ret;

    assign in_stall  = (state_reg != S_IDLE);
    assign merge_ret = (sts.op == OP_CONSUME) ? S_RNEXT : S_ACK;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (sts.op) inside
                    OP_INVALIDATE: state_next = sts.bad ? S_ACK : S_MINIT;
                    OP_SET, OP_CLEAR: state_next = sts.bad ? S_ACK : S_RREAD;
                    OP_QUERY:      state_next = sts.dirty_any ? S_PANS : S_RREAD;
                    OP_CONSUME:    state_next = S_RREAD;
                    default:       state_next = S_ACK;
                endcase
            end
            S_MINIT: state_next = S_MREAD;
            S_MREAD: state_next = sts.i_end ? merge_ret : S_MAE;
            S_MAE:   state_next = S_MAU;
            S_MAU:   state_next = S_MCMP;
            S_MCMP:  state_next = sts.fit ? merge_ret : S_MREAD;
            S_RREAD:
            begin
                if (!sts.k_end)
                begin
                    state_next = S_RCHK;
                end
                else
                begin
                    unique case (sts.op)
                        OP_QUERY:   state_next = S_PANS;
                        OP_CONSUME: state_next = S_EREAD;
                        OP_SET:     state_next = S_SNEW;
                        default:    state_next = S_ACK;
                    endcase
                end
            end
            S_RCHK:
            begin
                unique case (sts.op)
                    OP_SET:   state_next = sts.hit ? S_ACK : S_RNEXT;
                    OP_CLEAR: state_next = S_RNEXT;
                    default:  state_next = S_RDUE;
                endcase
            end
            S_RDUE:
            begin
                if (!sts.due)
                begin
                    state_next = S_RNEXT;
                end
                else
                begin
                    state_next = (sts.op == OP_QUERY) ? S_PANS : S_MINIT;
                end
            end
            S_RNEXT: state_next = S_RREAD;
            S_SNEW:  state_next = S_ACK;
            S_EREAD: state_next = sts.i_end ? S_EEND : S_ECLIP;
            S_ECLIP:
            begin
                if (!(sts.clip_ok && sts.hold_v && !sts.obuf_free))
                begin
                    state_next = S_EREAD;
                end
            end
            S_EEND, S_ACK, S_PANS:
            begin
                if (sts.obuf_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:   uop = UOP_IDLE;
            S_DECODE: uop = UOP_DECODE;
            S_MINIT:  uop = UOP_MINIT;
            S_MREAD:  uop = UOP_MREAD;
            S_MAE:    uop = UOP_MAE;
            S_MAU:    uop = UOP_MAU;
            S_MCMP:   uop = UOP_MCMP;
            S_RREAD:  uop = UOP_RREAD;
            S_RCHK:   uop = UOP_RCHK;
            S_RDUE:   uop = UOP_RDUE;
            S_RNEXT:  uop = UOP_RNEXT;
            S_SNEW:   uop = UOP_SNEW;
            S_EREAD:  uop = UOP_EREAD;
            S_ECLIP:  uop = UOP_ECLIP;
            S_EEND:   uop = UOP_EEND;
            S_ACK:    uop = UOP_ACK;
            S_PANS:   uop = UOP_PANS;
            default:  uop = UOP_IDLE;
        endcase
    end

endmodule

FILE: rtl/core/drfs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drfs_datapath
// Dirty list and region table memories, area multiplier, due check, clipping
// and the output word register.
// ----------------------------------------------------------------------------
module drfs_datapath import drfs_pkg::*; #(
    parameter int DIRTY_DEPTH  = DIRTY_DEPTH_DEF,
    parameter int REGION_DEPTH = REGION_DEPTH_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  uop_t                         uop,
    input  logic                         in_valid,
    input  logic [OP_BITS-1:0]           op,
    input  logic signed [COORD_BITS-1:0] rect_left,
    input  logic signed [COORD_BITS-1:0] rect_top,
    input  logic signed [COORD_BITS-1:0] rect_right,
    input  logic signed [COORD_BITS-1:0] rect_bottom,
    input  logic [ID_BITS-1:0]           region_id,
    input  logic [FPS_BITS-1:0]          target_fps,
    input  logic [TIME_BITS-1:0]         now_ms,
    input  logic signed [COORD_BITS-1:0] bound_left,
    input  logic signed [COORD_BITS-1:0] bound_top,
    input  logic signed [COORD_BITS-1:0] bound_right,
    input  logic signed [COORD_BITS-1:0] bound_bottom,
    input  logic                         out_stall,
    output sts_t                         sts,
    output logic                         out_valid,
    output logic [KIND_BITS-1:0]         kind,
    output logic [STAT_BITS-1:0]         status,
    output logic                         pending,
    output logic                         rect_valid,
    output logic signed [COORD_BITS-1:0] out_left,
    output logic signed [COORD_BITS-1:0] out_top,
    output logic signed [COORD_BITS-1:0] out_right,
    output logic signed [COORD_BITS-1:0] out_bottom,
    output logic                         last
);

    localparam int CB  = COORD_BITS;
    localparam int AB  = 2 * CB;
    localparam int DCW = $clog2(DIRTY_DEPTH + 1);
    localparam int DAW = (DIRTY_DEPTH > 1) ? $clog2(DIRTY_DEPTH) : 1;
    localparam int RCW = $clog2(REGION_DEPTH + 1);
    localparam int RAW = (REGION_DEPTH > 1) ? $clog2(REGION_DEPTH) : 1;

    typedef struct packed {
        logic signed [CB-1:0] l;
        logic signed [CB-1:0] t;
        logic signed [CB-1:0] r;
        logic signed [CB-1:0] b;
    } box_t;

    typedef struct packed {
        logic [ID_BITS-1:0]   id;
        box_t                 rect;
        logic [FPS_BITS-1:0]  fps;
        logic [TIME_BITS-1:0] last_ms;
        logic                 drawn;
    } rgn_t;

    function automatic logic [AB-1:0] f_area(input box_t a);
        logic [CB-1:0] w;
        logic [CB-1:0] h;
        w = a.r - a.l;
        h = a.b - a.t;
        return AB'(w) * AB'(h);
    endfunction

    function automatic box_t f_union(input box_t a, input box_t c);
        box_t m;
        m.l = (a.l < c.l) ? a.l : c.l;
        m.t = (a.t < c.t) ? a.t : c.t;
        m.r = (a.r > c.r) ? a.r : c.r;
        m.b = (a.b > c.b) ? a.b : c.b;
        return m;
    endfunction

    box_t dmem [DIRTY_DEPTH];
    rgn_t rmem [REGION_DEPTH];
    box_t drd_reg;
    rgn_t rrd_reg;

    logic [OP_BITS-1:0]   op_reg;
    box_t                 rect_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [FPS_BITS-1:0]  fps_reg;
    logic [TIME_BITS-1:0] now_reg;

    logic [DCW-1:0] dcnt_reg;
    logic [DCW-1:0] di_reg;
    logic [RCW-1:0] rcnt_reg;
    logic [RCW-1:0] rk_reg;
    logic [RCW-1:0] rj_reg;
    logic [STAT_BITS-1:0] stat_reg;
    logic pend_reg;
    logic hold_v_reg;
    box_t hold_reg;

    box_t cand_reg;
    box_t u_reg;
    logic [AB-1:0] aa_reg;
    logic [AB-1:0] ae_reg;
    logic [AB-1:0] au_reg;
    logic dge_reg;
    logic [MSP_BITS-1:0] dsm_reg;

    logic ovalid_reg;
    logic [KIND_BITS-1:0] okind_reg;
    logic [STAT_BITS-1:0] ostat_reg;
    logic opend_reg;
    logic orv_reg;
    box_t obox_reg;
    logic olast_reg;

    logic load;
    logic rect_empty;
    logic ignored;
    logic i_end;
    logic k_end;
    logic dfull;
    logic rfull;
    logic fit;
    logic hit;
    logic due;
    logic clip_ok;
    logic obuf_free;
    logic advance;
    box_t clip;
    logic [TIME_BITS-1:0] dt;
    logic [DUE_BITS-1:0] due_prod;

    logic dwe;
    logic [DAW-1:0] dwa;
    box_t dwd;
    logic dre;
    logic rwe;
    logic [RAW-1:0] rwa;
    rgn_t rwd;
    logic rre;

    logic emit;
    logic [KIND_BITS-1:0] e_kind;
    logic [STAT_BITS-1:0] e_stat;
    logic e_pend;
    logic e_rv;
    box_t e_box;
    logic e_last;

    assign load       = (uop == UOP_IDLE) && in_valid;
    assign rect_empty = !(rect_reg.r > rect_reg.l) || !(rect_reg.b > rect_reg.t);
    assign ignored    = ((op_reg == OP_INVALIDATE) && rect_empty)
                     || ((op_reg == OP_SET)
                         && ((id_reg == '0) || rect_empty || (fps_reg == '0)))
                     || ((op_reg == OP_CLEAR) && (id_reg == '0))
                     || (op_reg > OP_RESET);
    assign i_end      = (di_reg == dcnt_reg);
    assign k_end      = (rk_reg == rcnt_reg);
    assign dfull      = (dcnt_reg == DCW'(DIRTY_DEPTH));
    assign rfull      = (rcnt_reg == RCW'(REGION_DEPTH));
    assign fit        = ((AB + 2)'(au_reg)) <= ((AB + 2)'(ae_reg) + (AB + 2)'(aa_reg)) << 1;
    assign hit        = (rrd_reg.id == id_reg);
    assign dt         = now_reg - rrd_reg.last_ms;
    assign due_prod   = DUE_BITS'(dsm_reg) * DUE_BITS'(rrd_reg.fps);
    assign due        = !rrd_reg.drawn || dge_reg || (due_prod > DUE_BITS'(FRAME_MS));
    assign obuf_free  = !ovalid_reg || !out_stall;

    always_comb
    begin
        clip.l  = (drd_reg.l > bound_left)   ? drd_reg.l : bound_left;
        clip.t  = (drd_reg.t > bound_top)    ? drd_reg.t : bound_top;
        clip.r  = (drd_reg.r < bound_right)  ? drd_reg.r : bound_right;
        clip.b  = (drd_reg.b < bound_bottom) ? drd_reg.b : bound_bottom;
        clip_ok = (clip.r > clip.l) && (clip.b > clip.t);
    end

    assign advance = !(clip_ok && hold_v_reg && !obuf_free);

    always_comb
    begin
        sts.op        = op_reg;
        sts.bad       = ignored;
        sts.dirty_any = (dcnt_reg != '0);
        sts.i_end     = i_end;
        sts.k_end     = k_end;
        sts.fit       = fit;
        sts.hit       = hit;
        sts.due       = due;
        sts.clip_ok   = clip_ok;
        sts.hold_v    = hold_v_reg;
        sts.obuf_free = obuf_free;
    end

    // memory port control
    always_comb
    begin
        dwe = 1'b0;
        dwa = di_reg[DAW-1:0];
        dwd = u_reg;
        dre = 1'b0;
        rwe = 1'b0;
        rwa = rk_reg[RAW-1:0];
        rwd = rrd_reg;
        rre = 1'b0;
        case (uop)
            UOP_MREAD:
            begin
                if (i_end)
                begin
                    dwe = 1'b1;
                    if (dfull)
                    begin
                        dwa = DAW'(DIRTY_DEPTH - 1);
                    end
                    else
                    begin
                        dwa = dcnt_reg[DAW-1:0];
                        dwd = cand_reg;
                    end
                end
                else
                begin
                    dre = 1'b1;
                end
            end
            UOP_MCMP:  dwe = fit;
            UOP_EREAD: dre = !i_end;
            UOP_RREAD: rre = !k_end;
            UOP_RCHK:
            begin
                if ((op_reg == OP_SET) && hit)
                begin
                    rwe = 1'b1;
                    rwd.rect = rect_reg;
                    rwd.fps  = fps_reg;
                end
                else if ((op_reg == OP_CLEAR) && !hit)
                begin
                    rwe = 1'b1;
                    rwa = rj_reg[RAW-1:0];
                end
            end
            UOP_RDUE:
            begin
                if ((op_reg == OP_CONSUME) && due)
                begin
                    rwe = 1'b1;
                    rwd.last_ms = now_reg;
                    rwd.drawn   = 1'b1;
                end
            end
            UOP_SNEW:
            begin
                rwe = !rfull;
                rwa = rcnt_reg[RAW-1:0];
                rwd.id      = id_reg;
                rwd.rect    = rect_reg;
                rwd.fps     = fps_reg;
                rwd.last_ms = '0;
                rwd.drawn   = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dwe)
        begin
            dmem[dwa] <= dwd;
        end
        if (dre)
        begin
            drd_reg <= dmem[di_reg[DAW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rwe)
        begin
            rmem[rwa] <= rwd;
        end
        if (rre)
        begin
            rrd_reg <= rmem[rk_reg[RAW-1:0]];
        end
    end

    // result word selection
    always_comb
    begin
        emit   = 1'b0;
        e_kind = KIND_ACK;
        e_stat = stat_reg;
        e_pend = 1'b0;
        e_rv   = 1'b0;
        e_box  = '0;
        e_last = 1'b1;
        case (uop)
            UOP_ECLIP:
            begin
                emit   = clip_ok && hold_v_reg && obuf_free;
                e_kind = KIND_RECT;
                e_rv   = 1'b1;
                e_box  = hold_reg;
                e_last = 1'b0;
            end
            UOP_EEND:
            begin
                emit = obuf_free;
                if (hold_v_reg)
                begin
                    e_kind = KIND_RECT;
                    e_rv   = 1'b1;
                    e_box  = hold_reg;
                end
            end
            UOP_ACK:  emit = obuf_free;
            UOP_PANS:
            begin
                emit   = obuf_free;
                e_kind = KIND_PEND;
                e_stat = ST_OK;
                e_pend = pend_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg     <= OP_INVALIDATE;
            dcnt_reg   <= '0;
            di_reg     <= '0;
            rcnt_reg   <= '0;
            rk_reg     <= '0;
            rj_reg     <= '0;
            stat_reg   <= ST_OK;
            pend_reg   <= 1'b0;
            hold_v_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                op_reg     <= op;
                stat_reg   <= ST_OK;
                di_reg     <= '0;
                rk_reg     <= '0;
                rj_reg     <= '0;
                pend_reg   <= 1'b0;
                hold_v_reg <= 1'b0;
            end
            case (uop)
                UOP_DECODE:
                begin
                    if (op_reg == OP_RESET)
                    begin
                        dcnt_reg <= '0;
                        rcnt_reg <= '0;
                    end
                    if (ignored)
                    begin
                        stat_reg <= ST_IGNORED;
                    end
                    pend_reg <= (dcnt_reg != '0);
                end
                UOP_MINIT: di_reg <= '0;
                UOP_MREAD:
                begin
                    if (i_end)
                    begin
                        if (dfull)
                        begin
                            stat_reg <= ST_FULL_MERGE;
                        end
                        else
                        begin
                            dcnt_reg <= dcnt_reg + 1'b1;
                        end
                    end
                end
                UOP_MCMP:
                begin
                    if (!fit)
                    begin
                        di_reg <= di_reg + 1'b1;
                    end
                end
                UOP_RREAD:
                begin
                    if (k_end)
                    begin
                        di_reg <= '0;
                        if (op_reg == OP_CLEAR)
                        begin
                            rcnt_reg <= rj_reg;
                        end
                    end
                end
                UOP_RCHK:
                begin
                    if ((op_reg == OP_CLEAR) && !hit)
                    begin
                        rj_reg <= rj_reg + 1'b1;
                    end
                end
                UOP_RDUE:
                begin
                    if ((op_reg == OP_QUERY) && due)
                    begin
                        pend_reg <= 1'b1;
                    end
                end
                UOP_RNEXT: rk_reg <= rk_reg + 1'b1;
                UOP_SNEW:
                begin
                    if (rfull)
                    begin
                        stat_reg <= ST_TABLE_FULL;
                    end
                    else
                    begin
                        rcnt_reg <= rcnt_reg + 1'b1;
                    end
                end
                UOP_ECLIP:
                begin
                    if (advance)
                    begin
                        di_reg <= di_reg + 1'b1;
                        if (clip_ok)
                        begin
                            hold_v_reg <= 1'b1;
                        end
                    end
                end
                UOP_EEND:
                begin
                    if (obuf_free)
                    begin
                        dcnt_reg <= '0;
                    end
                end
                default:
                begin
                end
            endcase
            if (emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rect_reg <= '{l: rect_left, t: rect_top, r: rect_right, b: rect_bottom};
            id_reg   <= region_id;
            fps_reg  <= target_fps;
            now_reg  <= now_ms;
        end
        case (uop)
            UOP_DECODE: cand_reg <= rect_reg;
            UOP_MINIT:  aa_reg <= f_area(cand_reg);
            UOP_MAE:
            begin
                ae_reg <= f_area(drd_reg);
                u_reg  <= f_union(drd_reg, cand_reg);
            end
            UOP_MAU: au_reg <= f_area(u_reg);
            UOP_RCHK:
            begin
                dge_reg <= (dt >= TIME_BITS'(FRAME_MS));
                dsm_reg <= MSP_BITS'(dt[MS_BITS-1:0]) + 1'b1;
            end
            UOP_RDUE: cand_reg <= rrd_reg.rect;
            UOP_ECLIP:
            begin
                if (clip_ok && advance)
                begin
                    hold_reg <= clip;
                end
            end
            default:
            begin
            end
        endcase
        if (emit)
        begin
            okind_reg <= e_kind;
            ostat_reg <= e_stat;
            opend_reg <= e_pend;
            orv_reg   <= e_rv;
            obox_reg  <= e_box;
            olast_reg <= e_last;
        end
    end

    assign out_valid  = ovalid_reg;
    assign kind       = okind_reg;
    assign status     = ostat_reg;
    assign pending    = opend_reg;
    assign rect_valid = orv_reg;
    assign out_left   = obox_reg.l;
    assign out_top    = obox_reg.t;
    assign out_right  = obox_reg.r;
    assign out_bottom = obox_reg.b;
    assign last       = olast_reg;

endmodule

FILE: rtl/core/dirty_rect_frame_scheduler_core.sv
`timescale 1ns / 1ps
`include "dirty_rect_frame_scheduler_core_assert.svh"
// ----------------------------------------------------------------------------
// dirty_rect_frame_scheduler_core
// Dirty rectangle merge list and animated region table for a frame scheduler.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one command word; output channel
// (out_valid/out_stall) returns one or more result words, the final one with
// last set. A new command word is taken only once the previous one is fully
// processed; a finished result may still sit in the output register.
// Invalidate scans the dirty list (N entries, 16 by default); set and clear
// scan the region table (R regions, 8 by default), as does query when the
// dirty list is empty; consume adds one merge per due region and an
// emission pass over the dirty list.
// The user must write frame bounds on the cfg port while idle; not enforced.
// Reset empties both the dirty list and the region table and loads the
// default bounds 0, 0, 1920, 1080. A stalled receiver freezes the emitting
// step; the word in the output register holds until taken.
// ----------------------------------------------------------------------------
module dirty_rect_frame_scheduler_core import drfs_pkg::*; #(
    parameter int DIRTY_DEPTH  = DIRTY_DEPTH_DEF,
    parameter int REGION_DEPTH = REGION_DEPTH_DEF,
    parameter int COORD_BITS   = COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [COORD_BITS-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [OP_BITS-1:0]           op,
    input  logic signed [COORD_BITS-1:0] rect_left,
    input  logic signed [COORD_BITS-1:0] rect_top,
    input  logic signed [COORD_BITS-1:0] rect_right,
    input  logic signed [COORD_BITS-1:0] rect_bottom,
    input  logic [ID_BITS-1:0]           region_id,
    input  logic [FPS_BITS-1:0]          target_fps,
    input  logic [TIME_BITS-1:0]         now_ms,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [KIND_BITS-1:0]         kind,
    output logic [STAT_BITS-1:0]         status,
    output logic                         pending,
    output logic                         rect_valid,
    output logic signed [COORD_BITS-1:0] out_left,
    output logic signed [COORD_BITS-1:0] out_top,
    output logic signed [COORD_BITS-1:0] out_right,
    output logic signed [COORD_BITS-1:0] out_bottom,
    output logic                         last
);

    logic signed [COORD_BITS-1:0] bound_left_reg;
    logic signed [COORD_BITS-1:0] bound_top_reg;
    logic signed [COORD_BITS-1:0] bound_right_reg;
    logic signed [COORD_BITS-1:0] bound_bottom_reg;

    uop_t uop;
    sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_left_reg   <= COORD_BITS'(BOUND_LEFT_RST);
            bound_top_reg    <= COORD_BITS'(BOUND_TOP_RST);
            bound_right_reg  <= COORD_BITS'(BOUND_RIGHT_RST);
            bound_bottom_reg <= COORD_BITS'(BOUND_BOTTOM_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BOUND_LEFT:   bound_left_reg   <= cfg_data;
                REG_BOUND_TOP:    bound_top_reg    <= cfg_data;
                REG_BOUND_RIGHT:  bound_right_reg  <= cfg_data;
                REG_BOUND_BOTTOM: bound_bottom_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    drfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .uop      (uop)
    );

    drfs_datapath #(
        .DIRTY_DEPTH  (DIRTY_DEPTH),
        .REGION_DEPTH (REGION_DEPTH),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .uop          (uop),
        .in_valid     (in_valid),
        .op           (op),
        .rect_left    (rect_left),
        .rect_top     (rect_top),
        .rect_right   (rect_right),
        .rect_bottom  (rect_bottom),
        .region_id    (region_id),
        .target_fps   (target_fps),
        .now_ms       (now_ms),
        .bound_left   (bound_left_reg),
        .bound_top    (bound_top_reg),
        .bound_right  (bound_right_reg),
        .bound_bottom (bound_bottom_reg),
        .out_stall    (out_stall),
        .sts          (sts),
        .out_valid    (out_valid),
        .kind         (kind),
        .status       (status),
        .pending      (pending),
        .rect_valid   (rect_valid),
        .out_left     (out_left),
        .out_top      (out_top),
        .out_right    (out_right),
        .out_bottom   (out_bottom),
        .last         (last)
    );

    `DRFS_ASSERT_NEXT(a_accept_decodes, in_valid && !in_stall, uop == UOP_DECODE)
    `DRFS_ASSERT_NEXT(a_fit_leaves_scan, uop == UOP_MCMP && sts.fit,
                      uop == UOP_RNEXT || uop == UOP_ACK)
    `DRFS_ASSERT_SAME(a_word_source, $rose(out_valid),
                      $past(uop) == UOP_ECLIP || $past(uop) == UOP_EEND
                      || $past(uop) == UOP_ACK || $past(uop) == UOP_PANS)

endmodule

FILE: test/drfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drfs_checker
// Watches the command and result channels of the dirty rectangle scheduler,
// keeps its own copy of the dirty list, the region table and the frame bounds,
// predicts the result words of every accepted command, and compares each taken
// result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module drfs_checker import drfs_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [15:0]             cfg_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [OP_BITS-1:0]      op,
    input  logic signed [15:0]      rect_left,
    input  logic signed [15:0]      rect_top,
    input  logic signed [15:0]      rect_right,
    input  logic signed [15:0]      rect_bottom,
    input  logic [ID_BITS-1:0]      region_id,
    input  logic [FPS_BITS-1:0]     target_fps,
    input  logic [TIME_BITS-1:0]    now_ms,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [KIND_BITS-1:0]    kind,
    input  logic [STAT_BITS-1:0]    status,
    input  logic                    pending,
    input  logic                    rect_valid,
    input  logic signed [15:0]      out_left,
    input  logic signed [15:0]      out_top,
    input  logic signed [15:0]      out_right,
    input  logic signed [15:0]      out_bottom,
    input  logic                    last,
    output int                      errors,
    output int                      words_due
);

    typedef struct {
        longint l;
        longint t;
        longint r;
        longint b;
    } box_s;

    typedef struct {
        logic [KIND_BITS-1:0] kind;
        logic [STAT_BITS-1:0] status;
        logic                 pending;
        logic                 rect_valid;
        logic [15:0]          l;
        logic [15:0]          t;
        logic [15:0]          r;
        logic [15:0]          b;
        logic                 last;
    } word_s;

    word_s                result_q[$];
    longint               frame_l, frame_t, frame_r, frame_b;
    box_s                 dirty[16];
    int                   dirty_n;
    logic [ID_BITS-1:0]   reg_id[8];
    box_s                 reg_box[8];
    logic [FPS_BITS-1:0]  reg_fps[8];
    logic [TIME_BITS-1:0] reg_stamp[8];
    bit                   reg_drawn[8];
    int                   reg_n;

    function automatic void append_word(word_s w);
        result_q.insert(result_q.size(), w);
    endfunction

    function automatic bit is_empty(box_s a);
        return (a.r - a.l <= 0) || (a.b - a.t <= 0);
    endfunction

    function automatic longint box_area(box_s a);
        return (a.r - a.l) * (a.b - a.t);
    endfunction

    function automatic box_s box_join(box_s a, box_s b);
        box_s m;
        m.l = (a.l < b.l) ? a.l : b.l;
        m.t = (a.t < b.t) ? a.t : b.t;
        m.r = (a.r > b.r) ? a.r : b.r;
        m.b = (a.b > b.b) ? a.b : b.b;
        return m;
    endfunction

    // returns 1 when the list was full and the box went into the last entry
    function automatic bit add_dirty(box_s a);
        box_s m;
        for (int i = 0; i < dirty_n; i++)
        begin
            m = box_join(dirty[i], a);
            if (box_area(m) <= (box_area(dirty[i]) + box_area(a)) * 2)
            begin
                dirty[i] = m;
                return 0;
            end
        end
        if (dirty_n < 16)
        begin
            dirty[dirty_n] = a;
            dirty_n++;
            return 0;
        end
        dirty[15] = box_join(dirty[15], a);
        return 1;
    endfunction

    function automatic bit region_is_due(int i, logic [TIME_BITS-1:0] now);
        logic [TIME_BITS-1:0] gap;
        if (!reg_drawn[i])
            return 1;
        gap = now - reg_stamp[i];
        return gap >= TIME_BITS'(FRAME_MS / reg_fps[i]);
    endfunction

    function automatic word_s make_word(logic [KIND_BITS-1:0] k, logic [STAT_BITS-1:0] s,
                                        logic p, logic v, box_s a, logic lst);
        word_s w;
        w.kind = k;
        w.status = s;
        w.pending = p;
        w.rect_valid = v;
        w.l = a.l[15:0];
        w.t = a.t[15:0];
        w.r = a.r[15:0];
        w.b = a.b[15:0];
        w.last = lst;
        return w;
    endfunction

    task automatic predict_command();
        box_s                 a, c, zero;
        logic [STAT_BITS-1:0] st;
        bit                   p;
        int                   i, j, n;
        word_s                w;
        a.l = rect_left;
        a.t = rect_top;
        a.r = rect_right;
        a.b = rect_bottom;
        zero = '{0, 0, 0, 0};
        st = ST_OK;
        case (op)
            OP_INVALIDATE:
            begin
                if (is_empty(a))
                    st = ST_IGNORED;
                else if (add_dirty(a))
                    st = ST_FULL_MERGE;
            end
            OP_SET:
            begin
                if (region_id == 0 || is_empty(a) || target_fps == 0)
                    st = ST_IGNORED;
                else
                begin
                    for (i = 0; i < reg_n; i++)
                        if (reg_id[i] == region_id)
                            break;
                    if (i < reg_n)
                    begin
                        reg_box[i] = a;
                        reg_fps[i] = target_fps;
                    end
                    else if (reg_n < 8)
                    begin
                        reg_id[i] = region_id;
                        reg_box[i] = a;
                        reg_fps[i] = target_fps;
                        reg_stamp[i] = 0;
                        reg_drawn[i] = 0;
                        reg_n++;
                    end
                    else
                        st = ST_TABLE_FULL;
                end
            end
            OP_CLEAR:
            begin
                if (region_id == 0)
                    st = ST_IGNORED;
                else
                begin
                    j = 0;
                    for (i = 0; i < reg_n; i++)
                    begin
                        if (reg_id[i] != region_id)
                        begin
                            reg_id[j] = reg_id[i];
                            reg_box[j] = reg_box[i];
                            reg_fps[j] = reg_fps[i];
                            reg_stamp[j] = reg_stamp[i];
                            reg_drawn[j] = reg_drawn[i];
                            j++;
                        end
                    end
                    reg_n = j;
                end
            end
            OP_QUERY:
            begin
                p = dirty_n > 0;
                for (i = 0; i < reg_n && !p; i++)
                    if (region_is_due(i, now_ms))
                        p = 1;
                append_word(make_word(KIND_PEND, ST_OK, p, 0, zero, 1));
                return;
            end
            OP_CONSUME:
            begin
                for (i = 0; i < reg_n; i++)
                begin
                    if (region_is_due(i, now_ms))
                    begin
                        reg_stamp[i] = now_ms;
                        reg_drawn[i] = 1;
                        if (add_dirty(reg_box[i]))
                            st = ST_FULL_MERGE;
                    end
                end
                n = 0;
                for (i = 0; i < dirty_n; i++)
                begin
                    c = dirty[i];
                    if (c.l < frame_l) c.l = frame_l;
                    if (c.t < frame_t) c.t = frame_t;
                    if (c.r > frame_r) c.r = frame_r;
                    if (c.b > frame_b) c.b = frame_b;
                    if (!is_empty(c))
                    begin
                        append_word(make_word(KIND_RECT, st, 0, 1, c, 0));
                        n++;
                    end
                end
                dirty_n = 0;
                if (n > 0)
                begin
                    w = result_q.pop_back();
                    w.last = 1;
                    append_word(w);
                    return;
                end
            end
            OP_RESET:
            begin
                dirty_n = 0;
                reg_n = 0;
            end
            default: st = ST_IGNORED;
        endcase
        append_word(make_word(KIND_ACK, st, 0, 0, zero, 1));
    endtask

    task automatic check_word();
        word_s w;
        if (result_q.size() == 0)
        begin
            $error("result word with no prediction waiting");
            errors++;
            return;
        end
        w = result_q.pop_front();
        if (kind !== w.kind)
        begin
            $error("kind: expected %0d, actual %0d", w.kind, kind);
            errors++;
        end
        if (status !== w.status)
        begin
            $error("status: expected %0d, actual %0d", w.status, status);
            errors++;
        end
        if (pending !== w.pending)
        begin
            $error("pending: expected %0d, actual %0d", w.pending, pending);
            errors++;
        end
        if (rect_valid !== w.rect_valid)
        begin
            $error("rect_valid: expected %0d, actual %0d", w.rect_valid, rect_valid);
            errors++;
        end
        if (out_left !== w.l)
        begin
            $error("out_left: expected %0d, actual %0d", $signed(w.l), out_left);
            errors++;
        end
        if (out_top !== w.t)
        begin
            $error("out_top: expected %0d, actual %0d", $signed(w.t), out_top);
            errors++;
        end
        if (out_right !== w.r)
        begin
            $error("out_right: expected %0d, actual %0d", $signed(w.r), out_right);
            errors++;
        end
        if (out_bottom !== w.b)
        begin
            $error("out_bottom: expected %0d, actual %0d", $signed(w.b), out_bottom);
            errors++;
        end
        if (last !== w.last)
        begin
            $error("last: expected %0d, actual %0d", w.last, last);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors = 0;
            frame_l = BOUND_LEFT_RST;
            frame_t = BOUND_TOP_RST;
            frame_r = BOUND_RIGHT_RST;
            frame_b = BOUND_BOTTOM_RST;
            dirty_n = 0;
            reg_n = 0;
            result_q.delete();
            words_due = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BOUND_LEFT:   frame_l = $signed(cfg_data);
                    REG_BOUND_TOP:    frame_t = $signed(cfg_data);
                    REG_BOUND_RIGHT:  frame_r = $signed(cfg_data);
                    REG_BOUND_BOTTOM: frame_b = $signed(cfg_data);
                    default: ;
                endcase
            end
            // result first: a word taken at this edge belongs to an older command
            if (out_valid && !out_stall)
                check_word();
            if (in_valid && !in_stall)
                predict_command();
            words_due = result_q.size();
        end
    end

    final
    begin
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the dirty rectangle scheduler with directed and random command words
// under several frame bounds and idling patterns; the checker predicts and
// compares every result word, and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import drfs_pkg::*;

    localparam logic [OP_BITS-1:0] OP_UNDEF_LO = 3'd6;
    localparam logic [OP_BITS-1:0] OP_UNDEF_HI = 3'd7;
    localparam int  DRAIN_CYCLES = 1000;
    localparam int  HOLD_CYCLES  = 400;
    localparam longint CYCLE_LIMIT = 1500000;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [15:0]             cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [OP_BITS-1:0]      op;
    logic signed [15:0]      rect_left, rect_top, rect_right, rect_bottom;
    logic [ID_BITS-1:0]      region_id;
    logic [FPS_BITS-1:0]     target_fps;
    logic [TIME_BITS-1:0]    now_ms;
    logic                    out_valid;
    logic                    out_stall;
    logic [KIND_BITS-1:0]    kind;
    logic [STAT_BITS-1:0]    status;
    logic                    pending, rect_valid, last;
    logic signed [15:0]      out_left, out_top, out_right, out_bottom;
    int                      errors;
    int                      words_due;

    int                      send_idle_pct;
    int                      recv_idle_pct;
    bit                      hold_go;
    logic [TIME_BITS-1:0]    clock_ms;
    longint                  cycles;

    dirty_rect_frame_scheduler_core u_top (.*);

    drfs_checker u_chk (.*);

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // receiver side
    initial
    begin
        out_stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                hold_go = 0;
                out_stall = 1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                out_stall = ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic send_word(logic [OP_BITS-1:0] o, int l, int t, int r, int b,
                             logic [ID_BITS-1:0] id, logic [FPS_BITS-1:0] fps,
                             logic [TIME_BITS-1:0] now);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid = 0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
        @(negedge clk);
        op = o;
        rect_left = 16'(l);
        rect_top = 16'(t);
        rect_right = 16'(r);
        rect_bottom = 16'(b);
        region_id = id;
        target_fps = fps;
        now_ms = now;
        in_valid = 1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 0;
        while (words_due != 0)
            @(posedge clk);
    endtask

    task automatic write_bounds(int l, int t, int r, int b);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we = 1;
        cfg_index = REG_BOUND_LEFT;
        cfg_data = 16'(l);
        @(negedge clk);
        cfg_index = REG_BOUND_TOP;
        cfg_data = 16'(t);
        @(negedge clk);
        cfg_index = REG_BOUND_RIGHT;
        cfg_data = 16'(r);
        @(negedge clk);
        cfg_index = REG_BOUND_BOTTOM;
        cfg_data = 16'(b);
        @(negedge clk);
        cfg_we = 0;
    endtask

    task automatic random_word();
        int                   pick, l, t, w, h;
        logic [OP_BITS-1:0]   o;
        logic [ID_BITS-1:0]   id;
        logic [FPS_BITS-1:0]  fps;
        logic [TIME_BITS-1:0] now;
        pick = $urandom_range(0, 99);
        if (pick < 40)      o = OP_INVALIDATE;
        else if (pick < 55) o = OP_SET;
        else if (pick < 63) o = OP_CLEAR;
        else if (pick < 75) o = OP_QUERY;
        else if (pick < 93) o = OP_CONSUME;
        else if (pick < 96) o = OP_RESET;
        else if (pick < 98) o = OP_UNDEF_LO;
        else                o = OP_UNDEF_HI;
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            l = $signed($urandom_range(0, 2300)) - 200;
            t = $signed($urandom_range(0, 1400)) - 200;
            w = $urandom_range(1, 300);
            h = $urandom_range(1, 300);
        end
        else if (pick < 90)
        begin
            l = $signed(16'($urandom));
            t = $signed(16'($urandom));
            w = $urandom_range(0, 65535);
            h = $urandom_range(0, 65535);
            if (l + w > 32767) w = 32767 - l;
            if (t + h > 32767) h = 32767 - t;
        end
        else
        begin
            l = $signed($urandom_range(0, 2000));
            t = $signed($urandom_range(0, 1000));
            w = -$signed($urandom_range(0, 50));
            h = $urandom_range(1, 50);
        end
        id = ($urandom_range(0, 99) < 90) ? ID_BITS'($urandom_range(0, 10))
                                           : ID_BITS'($urandom);
        pick = $urandom_range(0, 99);
        fps = (pick < 5) ? '0 : (pick < 12) ? FPS_BITS'($urandom)
                                            : FPS_BITS'($urandom_range(1, 120));
        clock_ms += $urandom_range(0, 250);
        now = ($urandom_range(0, 99) < 5) ? TIME_BITS'({$urandom, $urandom}) : clock_ms;
        send_word(o, l, t, l + w, t + h, id, fps, now);
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = REG_BOUND_LEFT;
        cfg_data = 0;
        in_valid = 0;
        op = OP_INVALIDATE;
        rect_left = 0;
        rect_top = 0;
        rect_right = 0;
        rect_bottom = 0;
        region_id = 0;
        target_fps = 0;
        now_ms = 0;
        hold_go = 0;
        clock_ms = 5000;
        send_idle_pct = 20;
        recv_idle_pct = 78;
        repeat (11) @(negedge clk);
        rst_n = 1;

        // directed: extremes and every special case
        send_word(OP_INVALIDATE, -32768, -32768, 32767, 32767, 0, 0, 0);
        send_word(OP_INVALIDATE, 10, 10, 10, 20, 0, 0, 0);
        send_word(OP_QUERY, 0, 0, 0, 0, 0, 0, 0);
        send_word(OP_CONSUME, 0, 0, 0, 0, 0, 0, 100);
        send_word(OP_CONSUME, 0, 0, 0, 0, 0, 0, 200);
        send_word(OP_SET, 0, 0, 10, 10, 0, 30, 0);
        send_word(OP_SET, 0, 0, 0, 10, 5, 30, 0);
        send_word(OP_SET, 0, 0, 10, 10, 5, 0, 0);
        send_word(OP_SET, 0, 0, 10, 10, 16'hFFFF, 12'hFFF, 0);
        send_word(OP_SET, 50, 50, 80, 90, 16'hFFFF, 60, 0);
        send_word(OP_QUERY, 0, 0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF);
        send_word(OP_CONSUME, 0, 0, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF);
        send_word(OP_QUERY, 0, 0, 0, 0, 0, 0, 5);
        send_word(OP_QUERY, 0, 0, 0, 0, 0, 0, 16);
        send_word(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        send_word(OP_CLEAR, 0, 0, 0, 0, 77, 0, 0);
        send_word(OP_CLEAR, 0, 0, 0, 0, 16'hFFFF, 0, 0);
        for (int i = 1; i <= 9; i++)
            send_word(OP_SET, i * 30, 0, i * 30 + 5, 5, ID_BITS'(i), 1, 0);
        for (int i = 0; i < 17; i++)
            send_word(OP_INVALIDATE, i * 100, 500, i * 100 + 10, 510, 0, 0, 0);
        send_word(OP_CONSUME, 0, 0, 0, 0, 0, 0, 1000);
        for (int i = 0; i < 16; i++)
            send_word(OP_INVALIDATE, i * 100, 500, i * 100 + 10, 510, 0, 0, 0);
        send_word(OP_CONSUME, 0, 0, 0, 0, 0, 0, 1500);
        send_word(OP_UNDEF_LO, 0, 0, 0, 0, 0, 0, 0);
        send_word(OP_UNDEF_HI, 0, 0, 0, 0, 0, 0, 0);
        send_word(OP_RESET, 0, 0, 0, 0, 0, 0, 0);
        send_word(OP_CONSUME, 0, 0, 0, 0, 0, 0, 2000);

        write_bounds(-32768, -32768, 32767, 32767);
        repeat (25) random_word();

        write_bounds(100, 50, 600, 400);
        send_idle_pct = 78;
        recv_idle_pct = 20;
        repeat (25) random_word();

        write_bounds(32767, 32767, -32768, -32768);
        repeat (5) random_word();

        write_bounds(-300, -100, 1700, 900);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go = 1;
        for (int i = 0; i < 20; i++)
            send_word(OP_INVALIDATE, i * 90, i * 40, i * 90 + 30, i * 40 + 30, 0, 0, 0);
        wait_idle();
        send_word(OP_CONSUME, 0, 0, 0, 0, 0, 0, clock_ms);
        repeat (10) random_word();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
